[hw/rtl/rllt_pkg.sv]
`default_nettype none
package rllt_pkg;

	// Table sizing.
	localparam int MAX_RUNS  = 1024;
	localparam int MAX_BYTES = 65536;

	localparam int RUN_W  = $clog2(MAX_RUNS);
	localparam int CNT_W  = $clog2(MAX_BYTES + 1);
	localparam int LINE_W = 16;
	localparam int OFF_W  = 16;
	localparam int CMP_W  = (CNT_W > OFF_W) ? CNT_W : OFF_W;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BEYOND = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	// Item kinds carried on the input tuser.
	localparam logic OP_PUSH   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic item_acc;  // an input transaction completes this cycle
		logic walk_en;   // lookup walk is running
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_req;  // the offered lookup needs a walk over the runs
		logic walk_done; // the walk produces its result this cycle
		logic out_free;  // the result register can take a new result
	} sts_t;

endpackage
`default_nettype wire

[hw/rtl/rllt_ram.sv]
`default_nettype none
module rllt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hw/rtl/rllt_ctrl.sv]
`default_nettype none
module rllt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire rllt_pkg::sts_t sts,
	output rllt_pkg::cmd_t     cmd
);
	import rllt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WALK = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.item_acc = 1'b0;
		cmd.walk_en  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready     = sts.out_free;
				cmd.item_acc = s_tvalid && sts.out_free;
				if (cmd.item_acc && sts.walk_req) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk_en = 1'b1;
				if (sts.walk_done) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rllt_dp.sv]
`default_nettype none
module rllt_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_wdata,
	input  wire logic                        op,
	input  wire logic [rllt_pkg::LINE_W-1:0] line,
	input  wire logic [rllt_pkg::OFF_W-1:0]  offset,
	input  wire rllt_pkg::cmd_t              cmd,
	output rllt_pkg::sts_t                   sts,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [rllt_pkg::LINE_W-1:0]      line_out,
	output rllt_pkg::status_t                status
);
	import rllt_pkg::*;

	logic              en_q;
	logic [RUN_W-1:0]  last_run_q;
	logic [CNT_W-1:0]  total_q;
	logic [LINE_W-1:0] cur_line_q;
	logic [CNT_W-1:0]  cur_count_q;

	logic [RUN_W-1:0]  k_q;
	logic [RUN_W-1:0]  dk_q;
	logic              dv_q;
	logic [CNT_W-1:0]  acc_q;
	logic [OFF_W-1:0]  off_q;

	logic              out_valid_q;
	logic [LINE_W-1:0] out_line_q;
	status_t           out_status_q;

	logic              push_acc;
	logic              look_acc;
	logic              need_new;
	logic              bytes_full;
	logic              runs_full;
	logic              push_wr;
	logic [RUN_W-1:0]  wr_idx;
	logic [CNT_W-1:0]  wr_cnt;
	status_t           push_st;
	logic              beyond;

	logic [LINE_W-1:0] rd_line;
	logic [CNT_W-1:0]  rd_count;
	logic [CNT_W-1:0]  walk_sum;
	logic              walk_hit;
	logic              walk_miss;

	// Push decision.
	always_comb begin
		push_acc   = cmd.item_acc && (op == OP_PUSH);
		look_acc   = cmd.item_acc && (op == OP_LOOKUP);
		need_new   = (cur_line_q != '0) && (cur_line_q != line);
		bytes_full = total_q >= CNT_W'(MAX_BYTES);
		runs_full  = last_run_q == RUN_W'(MAX_RUNS - 1);
		push_st    = ST_OK;
		push_wr    = 1'b0;
		if (en_q) begin
			if (bytes_full || (need_new && runs_full)) begin
				push_st = ST_FULL;
			end else begin
				push_wr = push_acc;
			end
		end
		wr_idx = need_new ? last_run_q + RUN_W'(1) : last_run_q;
		wr_cnt = need_new ? CNT_W'(1) : cur_count_q + CNT_W'(1);
		beyond = CMP_W'(offset) >= CMP_W'(total_q);
	end

	// Walk compare on the entry read in the previous cycle.
	always_comb begin
		walk_sum  = acc_q + rd_count;
		walk_hit  = CMP_W'(off_q) < CMP_W'(walk_sum);
		walk_miss = !walk_hit && (dk_q == last_run_q);
	end

	always_comb begin
		sts.walk_req  = (op == OP_LOOKUP) && en_q && !beyond;
		sts.walk_done = cmd.walk_en && dv_q && (walk_hit || walk_miss);
		sts.out_free  = !out_valid_q || m_tready;
	end

	rllt_ram #(.WIDTH(LINE_W), .DEPTH(MAX_RUNS)) u_line_ram (
		.clk   (clk),
		.we    (push_wr),
		.waddr (wr_idx),
		.wdata (line),
		.raddr (k_q),
		.rdata (rd_line)
	);

	rllt_ram #(.WIDTH(CNT_W), .DEPTH(MAX_RUNS)) u_count_ram (
		.clk   (clk),
		.we    (push_wr),
		.waddr (wr_idx),
		.wdata (wr_cnt),
		.raddr (k_q),
		.rdata (rd_count)
	);

	// Table state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= 1'b1;
			last_run_q  <= '0;
			total_q     <= '0;
			cur_line_q  <= '0;
			cur_count_q <= '0;
		end else begin
			if (cfg_we) begin
				en_q <= cfg_wdata;
			end
			if (push_wr) begin
				last_run_q  <= wr_idx;
				total_q     <= total_q + CNT_W'(1);
				cur_line_q  <= line;
				cur_count_q <= wr_cnt;
			end
		end
	end

	// Walk registers; the read address runs one entry ahead of the compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= 1'b0;
		end else if (look_acc) begin
			dv_q <= 1'b0;
		end else begin
			dv_q <= cmd.walk_en && !sts.walk_done;
		end
	end

	always_ff @(posedge clk) begin
		if (look_acc) begin
			k_q   <= '0;
			acc_q <= '0;
			off_q <= offset;
		end else if (cmd.walk_en) begin
			k_q  <= k_q + RUN_W'(1);
			dk_q <= k_q;
			if (dv_q) begin
				acc_q <= walk_sum;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.item_acc && !sts.walk_req) || sts.walk_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.walk_done) begin
			out_line_q   <= walk_hit ? rd_line : '0;
			out_status_q <= walk_hit ? ST_OK : ST_BEYOND;
		end else if (push_acc) begin
			out_line_q   <= '0;
			out_status_q <= push_st;
		end else if (look_acc && !sts.walk_req) begin
			out_line_q   <= '0;
			out_status_q <= en_q ? ST_BEYOND : ST_OK;
		end
	end

	assign m_tvalid = out_valid_q;
	assign line_out = out_line_q;
	assign status   = out_status_q;

endmodule
`default_nettype wire

[hw/rtl/run_length_line_table.sv]
`default_nettype none
// Channel    Direction  Transaction contents
// s_axis     in         tdata: line[15:0], offset[31:16]; tuser: op (0 push, 1 lookup)
// m_axis     out        tdata: line_out[15:0], status[17:16], zeros[23:18]
// cfg        in         cfg_we with cfg_wdata: line_info_enabled
//
// Pushes are handled in the cycle they are accepted and can come on every cycle while
// each result is taken. A lookup that searches the table walks the runs from index 0
// to the run that holds the offset; one run is read per cycle.
// Reset is asynchronous; the table starts empty with line info enabled and no run is
// read before it is written, so there is no clearing pass.
// A result waiting on m_tready holds the input off until it is taken.
module run_length_line_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,   // line_info_enabled
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,     // line[15:0], offset[31:16]
	input  wire logic        s_tuser,     // op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata      // line_out[15:0], status[17:16]
);
	import rllt_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic [LINE_W-1:0] line_out;
	status_t           status;

	// The controller sequences transactions and the lookup walk.
	rllt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the run table, the walk accumulator and the result.
	rllt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op        (s_tuser),
		.line      (s_tdata[15:0]),
		.offset    (s_tdata[31:16]),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.line_out  (line_out),
		.status    (status)
	);

	assign m_tdata = {6'b0, status, line_out};

endmodule
`default_nettype wire
